// ----- sv/lpa_pkg.sv -----
// Shared types, constants and the divider step for the point-adjust block.
package lpa_pkg;

    // Mode register codes
    typedef enum logic [2:0] {
        MODE_PASS     = 3'd0,
        MODE_INVERT   = 3'd1,
        MODE_BRIGHTEN = 3'd2,
        MODE_DARKEN   = 3'd3,
        MODE_CONTRAST = 3'd4,
        MODE_SEPIA    = 3'd5
    } mode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MODE   = 2'd0,
        CFG_MAX    = 2'd1,
        CFG_EFFECT = 2'd2
    } cfg_idx_t;

    localparam int          CHAN_W      = 8;
    localparam int          EFFECT_W    = 9;
    localparam int          CFG_DATA_W  = 9;
    localparam logic [7:0]  MID_LEVEL   = 8'd127;
    localparam logic [6:0]  SEPIA_ADD_A = 7'd100;
    localparam logic [6:0]  SEPIA_ADD_B = 7'd50;
    localparam logic [6:0]  SEPIA_ADD_C = 7'd0;

    // Divider: 16-bit dividend (distance * |effect|), 8-bit divisor
    localparam int DIV_BITS    = 16;
    localparam int DIV_PER_STG = 4;
    localparam int DIV_STGS    = DIV_BITS / DIV_PER_STG;
    // One multiply stage in front of the divider stages
    localparam int NSTG        = DIV_STGS + 1;

    typedef struct packed {
        logic [CHAN_W-1:0]   rem;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] quo;
    } div_t;

    typedef struct packed {
        logic [CHAN_W-1:0] x;
        div_t              dv;
    } lstg_t;

    // Per-stage load strobes from the shared pipeline control
    typedef struct packed {
        logic [NSTG-1:0] load;
    } stg_en_t;

    // Four bits of restoring division; remainder stays below the divisor.
    function automatic div_t div_step(input div_t s, input logic [CHAN_W-1:0] d);
        div_t           r;
        logic [CHAN_W:0] cand;
        int             i;
        r = s;
        for (i = 0; i < DIV_PER_STG; i++)
        begin
            cand  = {r.rem, r.num[DIV_BITS-1]};
            r.num = {r.num[DIV_BITS-2:0], 1'b0};
            if (cand >= {1'b0, d})
            begin
                cand  = cand - {1'b0, d};
                r.quo = {r.quo[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                r.quo = {r.quo[DIV_BITS-2:0], 1'b0};
            end
            r.rem = cand[CHAN_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/lpa_div_stage.sv -----
// One registered stage of the pipelined contrast divider.
module lpa_div_stage
(
    input  logic                         clk,
    input  logic                         load,
    input  lpa_pkg::lstg_t               stg_in,
    input  logic [lpa_pkg::CHAN_W-1:0]   divisor,
    output lpa_pkg::lstg_t               stg_out
);

    lpa_pkg::lstg_t stg_reg;
    lpa_pkg::lstg_t stg_next;

    always_comb
    begin
        stg_next    = stg_in;
        stg_next.dv = lpa_pkg::div_step(stg_in.dv, divisor);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stg_reg <= stg_next;
        end
    end

    assign stg_out = stg_reg;

endmodule

// ----- sv/lpa_lane.sv -----
// One channel lane: distance product, divider stages, mode select and clamp.
module lpa_lane
(
    input  logic                             clk,
    input  lpa_pkg::stg_en_t                 en,
    input  logic [lpa_pkg::CHAN_W-1:0]       x,
    input  logic [2:0]                       mode,
    input  logic [lpa_pkg::CHAN_W-1:0]       max_value,
    input  logic signed [lpa_pkg::EFFECT_W-1:0] effect,
    input  logic [6:0]                       sepia_add,
    output logic [lpa_pkg::CHAN_W-1:0]       result
);

    lpa_pkg::lstg_t        p0_reg;
    lpa_pkg::lstg_t        p0_next;
    lpa_pkg::lstg_t        chain [0:lpa_pkg::DIV_STGS];

    logic [7:0]            spread;
    logic [8:0]            mag;
    logic signed [9:0]     eff_wide;
    logic [lpa_pkg::DIV_BITS-1:0] prod;

    lpa_pkg::lstg_t        last_stg;
    logic signed [17:0]    xs;
    logic signed [17:0]    qs;
    logic signed [17:0]    eff_ext;
    logic signed [17:0]    v;
    logic                  hi_side;

    // Front stage: |127 - x| * |effect|
    always_comb
    begin
        hi_side  = (x > lpa_pkg::MID_LEVEL);
        spread   = hi_side ? (x - lpa_pkg::MID_LEVEL) : (lpa_pkg::MID_LEVEL - x);
        eff_wide = {effect[8], effect};
        mag      = effect[8] ? 9'(-eff_wide) : 9'(eff_wide);
        prod     = {8'd0, spread} * {7'd0, mag};
        p0_next.x      = x;
        p0_next.dv.rem = '0;
        p0_next.dv.num = prod;
        p0_next.dv.quo = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en.load[0])
        begin
            p0_reg <= p0_next;
        end
    end

    assign chain[0] = p0_reg;

    genvar j;
    generate
        for (j = 0; j < lpa_pkg::DIV_STGS; j++)
        begin : g_div
            lpa_div_stage u_stage
            (
                .clk     (clk),
                .load    (en.load[j+1]),
                .stg_in  (chain[j]),
                .divisor (max_value),
                .stg_out (chain[j+1])
            );
        end
    endgenerate

    assign last_stg = chain[lpa_pkg::DIV_STGS];

    // Mode select and saturation on the last divider stage
    always_comb
    begin
        xs      = $signed({10'd0, last_stg.x});
        qs      = $signed({2'd0, last_stg.dv.quo});
        eff_ext = 18'(effect);
        unique case (lpa_pkg::mode_t'(mode))
            lpa_pkg::MODE_INVERT:   v = $signed({10'd0, max_value}) - xs;
            lpa_pkg::MODE_BRIGHTEN: v = xs + eff_ext;
            lpa_pkg::MODE_DARKEN:   v = xs - eff_ext;
            lpa_pkg::MODE_CONTRAST:
            begin
                // add when above mid-level with positive gain, or below with negative
                if ((last_stg.x > lpa_pkg::MID_LEVEL) ^ effect[8])
                    v = xs + qs;
                else
                    v = xs - qs;
            end
            lpa_pkg::MODE_SEPIA:    v = xs + $signed({11'd0, sepia_add});
            default:                v = xs;
        endcase

        if (max_value == '0)
            result = '0;
        else if (v < 0)
            result = '0;
        else if (v > $signed({10'd0, max_value}))
            result = max_value;
        else
            result = v[lpa_pkg::CHAN_W-1:0];
    end

endmodule

// ----- sv/lut_point_adjust_core.sv -----
// Top level of the colour-table point-adjust block: control, lanes, output register.
//
// Usage:
//   Source channel: src_valid / src_stall carry one table entry per transaction
//   (chan_a_in, chan_b_in, chan_c_in, last_in). Destination channel: dst_valid /
//   dst_stall carry the adjusted entry (chan_a_out, chan_b_out, chan_c_out,
//   last_out). A transaction completes on a rising edge with valid high and stall low.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 mode,
//   1 max_value, 2 effect); write only while no entry is in flight.
//   Pipeline: an accepted entry passes one multiply stage, four divider stages
//   at 4 quotient bits each, then the output register that also merges the
//   three lanes.
//   Throughput: one entry per cycle without stalls; channels run in parallel lanes.
//   Stalls: each pipeline stage loads when it is empty or its successor moves,
//   so bubbles collapse and entries keep arriving while a result waits;
//   src_stall rises only when all stages and the output are full, dst_stall high.
//   Reset: clears all valid bits and sets mode to pass, max_value to 255,
//   effect to 0. Payload registers are not reset.
module lut_point_adjust_core
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [lpa_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                               src_valid,
    output logic                               src_stall,
    input  logic [lpa_pkg::CHAN_W-1:0]         chan_a_in,
    input  logic [lpa_pkg::CHAN_W-1:0]         chan_b_in,
    input  logic [lpa_pkg::CHAN_W-1:0]         chan_c_in,
    input  logic                               last_in,

    output logic                               dst_valid,
    input  logic                               dst_stall,
    output logic [lpa_pkg::CHAN_W-1:0]         chan_a_out,
    output logic [lpa_pkg::CHAN_W-1:0]         chan_b_out,
    output logic [lpa_pkg::CHAN_W-1:0]         chan_c_out,
    output logic                               last_out
);

    localparam int NSTG = lpa_pkg::NSTG;

    // Configuration registers
    logic [2:0]                           mode_reg;
    logic [lpa_pkg::CHAN_W-1:0]           max_value_reg;
    logic signed [lpa_pkg::EFFECT_W-1:0]  effect_reg;

    // Pipeline control
    logic [NSTG-1:0]      valid_reg;
    logic [NSTG-1:0]      valid_next;
    logic [NSTG:0]        ready;
    logic [NSTG-1:0]      last_reg;
    lpa_pkg::stg_en_t     stg_en;
    logic                 out_free;

    // Output (merge) register
    logic                         out_valid_reg;
    logic [lpa_pkg::CHAN_W-1:0]   chan_a_reg;
    logic [lpa_pkg::CHAN_W-1:0]   chan_b_reg;
    logic [lpa_pkg::CHAN_W-1:0]   chan_c_reg;
    logic                         last_out_reg;

    logic [lpa_pkg::CHAN_W-1:0]   lane_a;
    logic [lpa_pkg::CHAN_W-1:0]   lane_b;
    logic [lpa_pkg::CHAN_W-1:0]   lane_c;

    // Register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= lpa_pkg::MODE_PASS;
            max_value_reg <= 8'd255;
            effect_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (lpa_pkg::cfg_idx_t'(cfg_index))
                lpa_pkg::CFG_MODE:   mode_reg      <= cfg_data[2:0];
                lpa_pkg::CFG_MAX:    max_value_reg <= cfg_data[lpa_pkg::CHAN_W-1:0];
                lpa_pkg::CFG_EFFECT: effect_reg    <= $signed(cfg_data);
                default:             ;
            endcase
        end
    end

    // Ready chain from the output back to the source: a stage may load when
    // it holds nothing or its contents move on this edge.
    always_comb
    begin
        out_free    = !out_valid_reg || !dst_stall;
        ready[NSTG] = out_free;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        stg_en.load = ready[NSTG-1:0];
        valid_next  = {valid_reg[NSTG-2:0], src_valid};
    end

    assign src_stall = !ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                if (ready[i])
                    valid_reg[i] <= valid_next[i];
            end
            if (out_free)
                out_valid_reg <= valid_reg[NSTG-1];
        end
    end

    // last mark rides alongside the lanes
    always_ff @(posedge clk)
    begin
        if (ready[0])
            last_reg[0] <= last_in;
        for (int i = 1; i < NSTG; i++)
        begin
            if (ready[i])
                last_reg[i] <= last_reg[i-1];
        end
    end

    lpa_lane u_lane_a
    (
        .clk       (clk),
        .en        (stg_en),
        .x         (chan_a_in),
        .mode      (mode_reg),
        .max_value (max_value_reg),
        .effect    (effect_reg),
        .sepia_add (lpa_pkg::SEPIA_ADD_A),
        .result    (lane_a)
    );

    lpa_lane u_lane_b
    (
        .clk       (clk),
        .en        (stg_en),
        .x         (chan_b_in),
        .mode      (mode_reg),
        .max_value (max_value_reg),
        .effect    (effect_reg),
        .sepia_add (lpa_pkg::SEPIA_ADD_B),
        .result    (lane_b)
    );

    lpa_lane u_lane_c
    (
        .clk       (clk),
        .en        (stg_en),
        .x         (chan_c_in),
        .mode      (mode_reg),
        .max_value (max_value_reg),
        .effect    (effect_reg),
        .sepia_add (lpa_pkg::SEPIA_ADD_C),
        .result    (lane_c)
    );

    // Merge stage: the three lane results and the mark into one transaction
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            chan_a_reg   <= lane_a;
            chan_b_reg   <= lane_b;
            chan_c_reg   <= lane_c;
            last_out_reg <= last_reg[NSTG-1];
        end
    end

    assign dst_valid  = out_valid_reg;
    assign chan_a_out = chan_a_reg;
    assign chan_b_out = chan_b_reg;
    assign chan_c_out = chan_c_reg;
    assign last_out   = last_out_reg;

`ifndef NO_ASSERTIONS
    // Source is held off only when the whole pipe is full behind a stalled result
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> (dst_valid && dst_stall && (&valid_reg)))
        else $error("source stalled with room in the pipeline");

    // Every channel result lies within the clamp limit
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> ((chan_a_out <= max_value_reg) && (chan_b_out <= max_value_reg)
                       && (chan_c_out <= max_value_reg)))
        else $error("result above max_value");

    // A new result only comes from a filled last lane stage
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> $past(valid_reg[NSTG-1]))
        else $error("result appeared without a source entry");
`endif

endmodule
